// ----- src/indexed_list_insert_erase_defines.svh -----
// assertion macros for the indexed list insert and erase block
`ifndef INDEXED_LIST_INSERT_ERASE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_DEFINES_SVH

`ifndef SYNTH

`define ILIE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ILIE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ILIE_ASSERT_IMP(name, ante, cons, msg)

`define ILIE_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ----- src/ilie_pkg.sv -----
// types and constants shared by the indexed list insert and erase block
`default_nettype none

package ilie_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic {
    ST_EMPTY = 1'b0,
    ST_HOLD  = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic [4:0]               count;
    logic signed [DATA_W-1:0] read_data;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic op_ins;
    logic op_era;
    logic op_rd;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

// ----- src/ilie_ctrl.sv -----
// controller: handshake state machine and request decode
`default_nettype none

module ilie_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ilie_pkg::req_t in_req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ilie_pkg::stat_t stat_i,
  output ilie_pkg::cmd_t     cmd_o
);
  import ilie_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        full;
  logic        pos_le_cnt;
  logic        pos_lt_cnt;

  assign full       = (stat_i.count == CNT_W'(CAPACITY));
  assign pos_le_cnt = (CMP_W'(in_req_i.position) <= CMP_W'(stat_i.count));
  assign pos_lt_cnt = (CMP_W'(in_req_i.position) <  CMP_W'(stat_i.count));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (in_valid_i) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_ready_i && !in_valid_i) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
    out_valid_o = (state_q == ST_HOLD);
    accept      = in_valid_i && in_ready_o;
    cmd_o       = '0;
    cmd_o.load  = accept;
    unique case (kind_e'(in_req_i.kind))
      KIND_INSERT: cmd_o.op_ins = accept && pos_le_cnt && !full;
      KIND_ERASE:  cmd_o.op_era = accept && pos_lt_cnt;
      KIND_READ:   cmd_o.op_rd  = accept && pos_lt_cnt;
      default:     cmd_o.op_ins = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ilie_dp.sv -----
// datapath: shifting entry cells, fill count and response register
`default_nettype none

`include "indexed_list_insert_erase_defines.svh"

module ilie_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ilie_pkg::req_t in_req_i,
  input  wire ilie_pkg::cmd_t cmd_i,
  output ilie_pkg::stat_t     stat_o,
  output ilie_pkg::rsp_t      rsp_o
);
  import ilie_pkg::*;

  logic [DATA_W-1:0] entries_q [CAPACITY];
  logic [DATA_W-1:0] entries_d [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  rsp_t              rsp_q, rsp_d;
  logic [CMP_W-1:0]  pos;

  assign pos = CMP_W'(in_req_i.position);

  // each cell takes the request value, its lower or its upper neighbor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_d[i] = entries_q[i];
      if (cmd_i.op_ins) begin
        if (CMP_W'(i) == pos) begin
          entries_d[i] = in_req_i.value;
        end else if (i > 0 && CMP_W'(i) > pos) begin
          entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.op_era) begin
        if (i < CAPACITY - 1 && CMP_W'(i) >= pos) begin
          entries_d[i] = entries_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.op_ins) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (cmd_i.op_era) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_comb begin
    rsp_d           = rsp_q;
    if (cmd_i.load) begin
      rsp_d.ok        = cmd_i.op_ins || cmd_i.op_era || cmd_i.op_rd;
      rsp_d.count     = 5'(count_d);
      rsp_d.read_data = cmd_i.op_rd ? entries_q[in_req_i.position[IDX_W-1:0]] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_q[i] <= entries_d[i];
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.count = count_q;
  assign rsp_o        = rsp_q;

  `ILIE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `ILIE_ASSERT_IMP(a_one_op, 1'b1, $onehot0({cmd_i.op_ins, cmd_i.op_era, cmd_i.op_rd}), "several ops at once")
  `ILIE_ASSERT_IMP(a_op_needs_load, cmd_i.op_ins || cmd_i.op_era || cmd_i.op_rd, cmd_i.load, "op without request")
  `ILIE_ASSERT_NXT(a_ins_grows, cmd_i.op_ins, count_q == CNT_W'($past(count_q) + 1'b1), "insert did not grow list")
  `ILIE_ASSERT_NXT(a_era_shrinks, cmd_i.op_era, count_q == CNT_W'($past(count_q) - 1'b1), "erase did not shrink list")
  `ILIE_ASSERT_NXT(a_rd_zero, cmd_i.load && !cmd_i.op_rd, rsp_q.read_data == '0, "read data not zero")

endmodule

`default_nettype wire

// ----- src/indexed_list_insert_erase.sv -----
// top level of the indexed list with insert, erase and read at a position
`default_nettype none

// Ordered list of up to 16 signed 32-bit entries with a fill count. Per accepted
// request the entry cells shift the whole tail up on an insert or down on an
// erase as they are registered, each cell loading its neighbor under a compare
// with the position. One response comes back per request, from an output
// register; a new request is taken in the cycle the pending response is taken,
// so a stream runs at one request per cycle while the output is ready. Failed
// requests (bad position, full list, unused kind) leave the list unchanged and
// report ok low. Reset clears only the count and control state, not the entries.
module indexed_list_insert_erase (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ilie_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ilie_pkg::rsp_t      out_rsp_o
);
  import ilie_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ilie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ilie_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire
